// ----- sv/masked_byte_pattern_search_unit_defines.svh -----
// Assertion macros shared by the masked byte pattern search unit.
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock, off during reset.
`define MBPS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, off during reset.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MBPS_ASSERT_IMP(label, ante, cons, msg)
`define MBPS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/mbps_pkg.sv -----
// Shared types and constants of the masked byte pattern search unit.
package mbps_pkg;

   localparam int PatternMaxDefault = 16;

   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 64;
   localparam int LengthWidth   = 5;
   localparam int CareWidth     = 16;
   localparam int OffsetWidth   = 32;

   localparam logic [CsrIndexWidth-1:0] CsrIdxPatternLow  = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CsrIdxPatternHigh = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] CsrIdxCareMask    = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] CsrIdxLength      = CsrIndexWidth'(3);

   typedef struct packed {
      logic [63:0]            pattern_low;
      logic [63:0]            pattern_high;
      logic [CareWidth-1:0]   care_mask;
      logic [LengthWidth-1:0] pattern_length;
   } cfg_type;

   typedef struct packed {
      logic                   found;
      logic [OffsetWidth-1:0] match_offset;
   } result_type;

endpackage

// ----- sv/mbps_csr_regs.sv -----
// Configuration register file of the masked byte pattern search unit.
module mbps_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mbps_pkg::CsrDataWidth-1:0]   csr_wdata,
   output mbps_pkg::cfg_type                   cfg
);

   mbps_pkg::cfg_type cfg_ff;
   mbps_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mbps_pkg::CsrIdxPatternLow:  cfg_in.pattern_low  = csr_wdata;
            mbps_pkg::CsrIdxPatternHigh: cfg_in.pattern_high = csr_wdata;
            mbps_pkg::CsrIdxCareMask: begin
               cfg_in.care_mask = csr_wdata[mbps_pkg::CareWidth-1:0];
            end
            mbps_pkg::CsrIdxLength: begin
               cfg_in.pattern_length = csr_wdata[mbps_pkg::LengthWidth-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/mbps_scan_core.sv -----
// Byte window, region counter and masked signature compare.
module mbps_scan_core #(
   parameter int PATTERN_MAX = mbps_pkg::PatternMaxDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mbps_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  logic [7:0]           item_byte,
   input  logic                 item_last,
   input  logic                 advance,
   output logic                 res_valid,
   output mbps_pkg::result_type res
);

   localparam int LenW = $clog2(PATTERN_MAX + 1);
   localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int OffW = mbps_pkg::OffsetWidth;

   logic [7:0]      window_ff [PATTERN_MAX];
   logic [7:0]      window_in [PATTERN_MAX];
   logic [OffW-1:0] pos_ff;
   logic [OffW-1:0] pos_in;
   logic [OffW-1:0] pos_next;
   logic            found_ff;
   logic            found_in;

   logic [LenW-1:0] len_eff;
   logic [127:0]    sig_bits;
   logic            all_ok;
   logic            match;
   logic [LenW-1:0] tap;

   // Window after this byte shifts in; newest byte at index 0.
   always_comb begin
      window_in[0] = item_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   assign pos_next = (pos_ff == '1) ? pos_ff : pos_ff + OffW'(1);

   // Clamp the length to the window depth.
   always_comb begin
      if (cfg.pattern_length > mbps_pkg::LengthWidth'(PATTERN_MAX)) begin
         len_eff = LenW'(PATTERN_MAX);
      end else begin
         len_eff = cfg.pattern_length[LenW-1:0];
      end
   end

   assign sig_bits = {cfg.pattern_high, cfg.pattern_low};

   // Signature byte j lines up with window byte len-1-j.
   always_comb begin
      all_ok = 1'b1;
      tap    = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         tap = len_eff - LenW'(j + 1);
         if ((LenW'(j) < len_eff) && cfg.care_mask[j]) begin
            if (window_in[tap[IdxW-1:0]] != sig_bits[j*8 +: 8]) begin
               all_ok = 1'b0;
            end
         end
      end
   end

   assign match = !found_ff && (len_eff != '0) && (pos_next >= OffW'(len_eff)) && all_ok;

   always_comb begin
      res_valid        = item_valid && (match || (item_last && !found_ff));
      res.found        = match;
      res.match_offset = match ? (pos_next - OffW'(len_eff)) : '0;
   end

   // A last byte closes the region.
   always_comb begin
      pos_in   = pos_ff;
      found_in = found_ff;
      if (advance) begin
         if (item_last) begin
            pos_in   = '0;
            found_in = 1'b0;
         end else begin
            pos_in   = pos_next;
            found_in = found_ff || match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

   // Window contents before a region start are never compared, so no clear.
   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- sv/masked_byte_pattern_search_unit.sv -----
// Top level of the masked byte pattern search unit.
// Scans a region streamed one byte per item (tlast marks the region's final
// byte) for the first place where the configured signature of up to
// PATTERN_MAX bytes matches; signature bytes whose care bit is clear match
// anything. The first complete match inside the region yields one result with
// tuser = 1 and the start offset in tdata; a region that ends without a match
// yields one result with tuser = 0 and offset 0. A length of zero never
// matches, and a length above PATTERN_MAX counts as PATTERN_MAX. The block
// takes one byte every cycle unless a byte with a result meets a full output
// register: the byte is registered, compared against the whole window in one
// pass of parallel byte compares, and the result lands in an output register
// as the byte advances. Bytes that give no result move on even while a result
// waits to be taken. Offsets count from the saturating 32-bit byte counter.
// Configuration writes are always ready; the user must make them while no byte
// is in flight (the block does not enforce it); no clearing pass after reset.
`include "masked_byte_pattern_search_unit_defines.svh"

module masked_byte_pattern_search_unit #(
   parameter int PATTERN_MAX = mbps_pkg::PatternMaxDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // Byte stream in.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // last_byte
   // Results out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // [31:0] match_offset
   output logic                                rsp_tuser,   // [0] found
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mbps_pkg::CsrDataWidth-1:0]   csr_wdata
);

   mbps_pkg::cfg_type    cfg;
   mbps_pkg::result_type res;
   logic                 res_valid;
   logic                 advance;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   mbps_pkg::result_type out_res_ff;

   mbps_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbps_scan_core #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (in_valid_ff),
      .item_byte  (in_byte_ff),
      .item_last  (in_last_ff),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Advance the held byte unless it has a result and the output slot stays full.
   assign advance    = in_valid_ff && (!res_valid || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the payload only on acceptance; hold it otherwise.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.found;
   assign rsp_tdata  = out_res_ff.match_offset;

   // A result never overwrites one that has not been taken.
   `MBPS_ASSERT_IMP(a_no_overwrite, advance && res_valid, !out_valid_ff || rsp_tready, "result overwritten")
   // A held byte stays put until it advances.
   `MBPS_ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff), "held byte changed")
   // A not-found result carries a zero offset.
   `MBPS_ASSERT_IMP(a_zero_offset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "nonzero offset without match")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the masked byte pattern search unit.
`timescale 1ns / 100ps

module tb_top;

   localparam int PatternMax  = mbps_pkg::PatternMaxDefault;
   // Leave margin for bytes in flight.
   localparam int DrainCycles = 6;
   localparam int CycleLimit  = 400000;

   logic                               clock;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = '0;   // [7:0] data_byte
   logic                               req_tlast  = 1'b0; // last_byte
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [31:0]                        rsp_tdata;         // [31:0] match_offset
   logic                               rsp_tuser;         // [0] found
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [mbps_pkg::CsrIndexWidth-1:0] csr_index  = '0;
   logic [mbps_pkg::CsrDataWidth-1:0]  csr_wdata  = '0;

   masked_byte_pattern_search_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Scan predictor state: signature settings plus the per-region window.
   mbps_pkg::cfg_type sig_cfg = '0;
   logic [7:0]        scan_window [PatternMax];
   logic [31:0]       scan_count;
   logic              scan_hit;

   // Verdicts the block still owes, oldest first.
   mbps_pkg::result_type pending_verdicts [$];
   logic [7:0]           region_bytes [$];

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int items_sent     = 0;
   int regions_sent   = 0;
   int settings_used  = 0;
   int matches_seen   = 0;
   int misses_seen    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Forget everything about the current region.
   function automatic void clear_region_state();
      foreach (scan_window[i]) scan_window[i] = '0;
      scan_count = '0;
      scan_hit   = 1'b0;
   endfunction

   // Lengths above the window size act as a full window.
   function automatic int unsigned effective_length();
      return (sig_cfg.pattern_length > PatternMax) ? PatternMax : sig_cfg.pattern_length;
   endfunction

   function automatic logic [7:0] signature_byte(input int j);
      logic [127:0] sig;
      sig = {sig_cfg.pattern_high, sig_cfg.pattern_low};
      return sig[j*8 +: 8];
   endfunction

   // Shift in one accepted byte and queue the verdict it causes, if any.
   function automatic void predict_scan_byte(input logic [7:0] b, input logic last);
      int unsigned          len;
      logic                 hit;
      mbps_pkg::result_type verdict;
      len = effective_length();
      for (int i = PatternMax - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
      scan_window[0] = b;
      if (scan_count != '1) scan_count++;
      // Only test once the whole signature fits inside the region.
      if (!scan_hit && len != 0 && scan_count >= len) begin
         hit = 1'b1;
         for (int j = 0; j < len; j++) begin
            if (sig_cfg.care_mask[j] && scan_window[len-1-j] != signature_byte(j)) hit = 1'b0;
         end
         if (hit) begin
            scan_hit             = 1'b1;
            verdict.found        = 1'b1;
            verdict.match_offset = scan_count - 32'(len);
            pending_verdicts.push_back(verdict);
            matches_seen++;
         end
      end
      if (last) begin
         if (!scan_hit) begin
            verdict.found        = 1'b0;
            verdict.match_offset = '0;
            pending_verdicts.push_back(verdict);
            misses_seen++;
         end
         clear_region_state();
      end
   endfunction

   // Offer one byte, idling at random first; return once it is taken.
   // Leave tvalid high so back-to-back bytes need no extra assignment.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_scan_byte(b, last);
      items_sent++;
   endtask

   task automatic send_region();
      foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
      regions_sent++;
   endtask

   // Drop tvalid, wait for every owed verdict, then let the pipeline drain.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write all four registers back to back; junk above the field widths.
   task automatic write_signature(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [15:0] care, input logic [4:0] len);
      logic [mbps_pkg::CsrIndexWidth-1:0] idx [4];
      logic [63:0]                        vals [4];
      idx  = '{mbps_pkg::CsrIdxPatternLow, mbps_pkg::CsrIdxPatternHigh,
               mbps_pkg::CsrIdxCareMask, mbps_pkg::CsrIdxLength};
      vals = '{lo, hi, {$urandom, $urandom}, {$urandom, $urandom}};
      vals[2][15:0] = care;
      vals[3][4:0]  = len;
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      sig_cfg.pattern_low    = lo;
      sig_cfg.pattern_high   = hi;
      sig_cfg.care_mask      = care;
      sig_cfg.pattern_length = len;
      settings_used++;
   endtask

   // Reset settings have length zero: a region can only miss.
   task automatic test_zero_length();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // One wildcard byte hits at offset 0; the next byte is silent and clears.
   task automatic test_single_wildcard();
      wait_idle();
      write_signature('0, '0, 16'h0000, 5'd1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // A region shorter than the signature misses even with all wildcards.
   task automatic test_short_region();
      wait_idle();
      write_signature('1, '1, 16'h0000, 5'd3);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);
   endtask

   // Length 31 acts as 16; the full signature completes on the last byte.
   task automatic test_clamped_full_signature();
      wait_idle();
      write_signature(64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF, 16'hFFFF, 5'd31);
      for (int j = 0; j < PatternMax; j++) send_byte(signature_byte(j), j == PatternMax - 1);
   endtask

   // Mostly short signatures so regions stay short and verdicts frequent.
   task automatic apply_random_signature();
      logic [63:0] lo, hi;
      logic [15:0] care;
      logic [4:0]  len;
      int          pick;
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0) begin
         lo = '0;
         hi = '1;
      end else if (pick == 1) begin
         lo = '1;
         hi = '0;
      end
      pick = $urandom_range(99);
      if (pick < 55)      len = 5'($urandom_range(1, 4));
      else if (pick < 70) len = 5'($urandom_range(5, 15));
      else if (pick < 80) len = 5'd16;
      else if (pick < 90) len = 5'($urandom_range(17, 31));
      else                len = 5'd0;
      pick = $urandom_range(9);
      care = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      write_signature(lo, hi, care, len);
   endtask

   // Fill a region with noise biased toward signature bytes, and usually
   // plant the signature; sometimes let it run off the region's end.
   task automatic build_region();
      int          size, at;
      int unsigned len;
      region_bytes.delete();
      size = ($urandom_range(9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 20);
      len  = effective_length();
      for (int i = 0; i < size; i++) begin
         if (len != 0 && $urandom_range(3) == 0)
            region_bytes.push_back(signature_byte($urandom_range(len - 1)));
         else
            region_bytes.push_back(8'($urandom_range(255)));
      end
      if (len != 0 && $urandom_range(99) < 70) begin
         if (size >= len && $urandom_range(4) != 0) at = $urandom_range(size - len);
         else at = $urandom_range(size - 1);
         for (int j = 0; j < len && at + j < size; j++) begin
            if (sig_cfg.care_mask[j]) region_bytes[at+j] = signature_byte(j);
         end
      end
   endtask

   // Random signatures and regions under one idling pattern.
   task automatic test_random_scan(input int idle_pct, input int stall_pct, input int budget);
      int start;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      start         = items_sent;
      while (items_sent - start < budget) begin
         wait_idle();
         apply_random_signature();
         repeat ($urandom_range(3, 10)) begin
            build_region();
            send_region();
         end
      end
   endtask

   // Compare each taken verdict with the oldest owed one; stall at random.
   always @(posedge clock) begin
      mbps_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result: found=%0b match_offset=%0d", rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== want.match_offset) begin
                  $error("match_offset: expected %0d, got %0d", want.match_offset, rsp_tdata);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d verdicts still owed",
                  cycle_count, pending_verdicts.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clear_region_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_length();
      test_single_wildcard();
      test_short_region();
      test_clamped_full_signature();

      test_random_scan(15, 59, 330);
      test_random_scan(59, 15, 330);
      test_random_scan(0, 0, 330);

      wait_idle();
      $display("Scanned %0d bytes in %0d regions under %0d signature settings,",
               items_sent, regions_sent, settings_used);
      $display("with %0d matches and %0d misses predicted and checked.",
               matches_seen, misses_seen);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
